/* rtl/packet_reorder_buffer_core_macros.svh */
// ----------------------------------------------------------------------------
// packet reorder buffer assertion macros
// shared concurrent assertion forms, sampled on clk and off during reset
// ----------------------------------------------------------------------------
`ifndef PACKET_REORDER_BUFFER_CORE_MACROS_SVH
`define PACKET_REORDER_BUFFER_CORE_MACROS_SVH

// property must hold on every clock outside reset
`define PRB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define PRB_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

/* rtl/prb_pkg.sv */
// ----------------------------------------------------------------------------
// prb_pkg
// field widths, register indexes, reset values and controller/datapath types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prb_pkg;

	localparam int GROUP_W  = 32;
	localparam int HANDLE_W = 16;
	localparam int LEN_W    = 16;
	localparam int TIME_W   = 32;
	localparam int LIMIT_W  = 5;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 1;

	localparam int DEPTH_DEFAULT = 16;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET   = LIMIT_W'(16);
	localparam logic [TIME_W-1:0]  TIMEOUT_RESET = TIME_W'(1000);

	localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_US  = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic insert;     // put the incoming descriptor into the sorted buffer
		logic pop;        // move head into the pending slot and shift the buffer
		logic emit;       // drive the pending slot out as a result beat
		logic emit_last;  // the emitted beat closes this insert
	} prb_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic head_go;    // buffer not empty and head meets a release rule
	} prb_stat_t;

endpackage

/* rtl/prb_datapath.sv */
// ----------------------------------------------------------------------------
// prb_datapath
// sorted descriptor buffer, release rule evaluation, config and result regs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packet_reorder_buffer_core_macros.svh"

module prb_datapath #(
	parameter int DEPTH = prb_pkg::DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  prb_pkg::prb_cmd_t             cmd,
	output prb_pkg::prb_stat_t            stat,
	input  logic                          cfg_we,
	input  logic [prb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [prb_pkg::CFG_W-1:0]     cfg_data,
	input  logic [prb_pkg::GROUP_W-1:0]   group_id,
	input  logic [prb_pkg::HANDLE_W-1:0]  packet_handle,
	input  logic [prb_pkg::LEN_W-1:0]     packet_length,
	input  logic [prb_pkg::TIME_W-1:0]    now_us,
	output logic                          result_valid,
	output logic [prb_pkg::GROUP_W-1:0]   released_group,
	output logic [prb_pkg::HANDLE_W-1:0]  released_handle,
	output logic [prb_pkg::LEN_W-1:0]     released_length,
	output logic                          last_release
);
	import prb_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

	logic [GROUP_W-1:0]  grp_q [DEPTH];
	logic [HANDLE_W-1:0] hdl_q [DEPTH];
	logic [LEN_W-1:0]    len_q [DEPTH];
	logic [TIME_W-1:0]   arr_q [DEPTH];
	logic [CW-1:0]       cnt_q;
	logic [GROUP_W-1:0]  last_rel_q;
	logic [TIME_W-1:0]   now_q;
	logic [LIMIT_W-1:0]  max_q;
	logic [TIME_W-1:0]   timeout_q;

	logic [GROUP_W-1:0]  pend_grp_q;
	logic [HANDLE_W-1:0] pend_hdl_q;
	logic [LEN_W-1:0]    pend_len_q;

	logic                valid_q;
	logic [GROUP_W-1:0]  out_grp_q;
	logic [HANDLE_W-1:0] out_hdl_q;
	logic [LEN_W-1:0]    out_len_q;
	logic                out_last_q;

	logic [DEPTH-1:0]    le;
	logic [LW-1:0]       lim_eff;
	logic [TIME_W-1:0]   age;
	logic [GROUP_W-1:0]  head_m1;

	// entries at or below the new id stay, the rest move up one place
	always_comb begin
		for (int k = 0; k < DEPTH; k++) begin
			le[k] = (CW'(k) < cnt_q) && (grp_q[k] <= group_id);
		end
	end

	always_comb begin
		lim_eff = (LW'(max_q) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(max_q);
		age     = now_q - arr_q[0];
		head_m1 = grp_q[0] - GROUP_W'(1);
		stat.head_go = (cnt_q != '0) &&
			((age >= timeout_q) || (LW'(cnt_q) >= lim_eff) ||
			 (grp_q[0] == last_rel_q) || (last_rel_q >= head_m1));
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			now_q <= now_us;
			for (int k = 0; k < DEPTH; k++) begin
				if (!le[k]) begin
					if (k == 0 || le[(k == 0) ? 0 : k - 1]) begin
						grp_q[k] <= group_id;
						hdl_q[k] <= packet_handle;
						len_q[k] <= packet_length;
						arr_q[k] <= now_us;
					end else begin
						grp_q[k] <= grp_q[(k == 0) ? 0 : k - 1];
						hdl_q[k] <= hdl_q[(k == 0) ? 0 : k - 1];
						len_q[k] <= len_q[(k == 0) ? 0 : k - 1];
						arr_q[k] <= arr_q[(k == 0) ? 0 : k - 1];
					end
				end
			end
		end else if (cmd.pop) begin
			for (int k = 0; k < DEPTH - 1; k++) begin
				grp_q[k] <= grp_q[k + 1];
				hdl_q[k] <= hdl_q[k + 1];
				len_q[k] <= len_q[k + 1];
				arr_q[k] <= arr_q[k + 1];
			end
		end
		if (cmd.pop) begin
			pend_grp_q <= grp_q[0];
			pend_hdl_q <= hdl_q[0];
			pend_len_q <= len_q[0];
		end
		if (cmd.emit) begin
			out_grp_q  <= pend_grp_q;
			out_hdl_q  <= pend_hdl_q;
			out_len_q  <= pend_len_q;
			out_last_q <= cmd.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			last_rel_q <= '0;
			max_q      <= LIMIT_RESET;
			timeout_q  <= TIMEOUT_RESET;
			valid_q    <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
			if (cmd.insert) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.pop) begin
				cnt_q      <= cnt_q - CW'(1);
				last_rel_q <= grp_q[0];
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAX_ENTRIES: max_q     <= cfg_data[LIMIT_W-1:0];
					REG_TIMEOUT_US:  timeout_q <= cfg_data[TIME_W-1:0];
					default: ;
				endcase
			end
		end
	end

	assign result_valid    = valid_q;
	assign released_group  = out_grp_q;
	assign released_handle = out_hdl_q;
	assign released_length = out_len_q;
	assign last_release    = out_last_q;

	`PRB_NEVER(a_cnt_overflow, cnt_q > CW'(DEPTH), "occupancy above depth")
	`PRB_NEVER(a_pop_empty, cmd.pop && (cnt_q == '0), "pop from empty buffer")
	`PRB_ASSERT(a_pop_count, cmd.pop |=> cnt_q == $past(cnt_q) - CW'(1), "pop count slip")

endmodule

/* rtl/prb_ctrl.sv */
// ----------------------------------------------------------------------------
// prb_ctrl
// sequences one insert followed by head releases until no rule applies
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packet_reorder_buffer_core_macros.svh"

module prb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  prb_pkg::prb_stat_t stat,
	output prb_pkg::prb_cmd_t  cmd
);
	import prb_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE    = 2'b01,
		ST_RELEASE = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   pend_q;  // a popped head waits in the pending slot

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.insert = 1'b1;
					state_d    = ST_RELEASE;
				end
			end
			ST_RELEASE: begin
				cmd.emit = pend_q;
				if (stat.head_go) begin
					cmd.pop = 1'b1;
				end else begin
					// nothing more goes, so the pending beat is the last one
					cmd.emit_last = pend_q;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= cmd.pop;
		end
	end

	assign busy = (state_q != ST_IDLE);

	`PRB_ASSERT(a_last_to_idle, cmd.emit_last |=> state_q == ST_IDLE, "last beat not closing")
	`PRB_ASSERT(a_start_release, (start && !busy) |=> state_q == ST_RELEASE, "start not taken")
	`PRB_NEVER(a_pop_idle, cmd.pop && (state_q == ST_IDLE), "pop while idle")

endmodule

/* rtl/packet_reorder_buffer_core.sv */
// ----------------------------------------------------------------------------
// packet_reorder_buffer_core
// reorder buffer for packet descriptors, released in group order with timeout
// ----------------------------------------------------------------------------
// busy is high from start until the insert and all head releases of an item are done
// the parallel sorted insert comes first, then the head releases one at a time
// result beats follow one per cycle, one for each head release
// beats cannot be held off by the receiver
// arst_n clears occupancy, last released id, config to limit 16 and 1000 us
`timescale 1ns / 1ps

module packet_reorder_buffer_core #(
	parameter int DEPTH = prb_pkg::DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cfg_we,
	input  logic [prb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [prb_pkg::CFG_W-1:0]     cfg_data,
	input  logic [prb_pkg::GROUP_W-1:0]   group_id,
	input  logic [prb_pkg::HANDLE_W-1:0]  packet_handle,
	input  logic [prb_pkg::LEN_W-1:0]     packet_length,
	input  logic [prb_pkg::TIME_W-1:0]    now_us,
	output logic                          result_valid,
	output logic [prb_pkg::GROUP_W-1:0]   released_group,
	output logic [prb_pkg::HANDLE_W-1:0]  released_handle,
	output logic [prb_pkg::LEN_W-1:0]     released_length,
	output logic                          last_release
);
	import prb_pkg::*;

	prb_cmd_t  cmd;
	prb_stat_t stat;

	prb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	prb_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.group_id        (group_id),
		.packet_handle   (packet_handle),
		.packet_length   (packet_length),
		.now_us          (now_us),
		.result_valid    (result_valid),
		.released_group  (released_group),
		.released_handle (released_handle),
		.released_length (released_length),
		.last_release    (last_release)
	);

endmodule
